// File: rtl/lis_pkg.sv
// ----------------------------------------------------------------------------
// lis_pkg
// Shared sizes, codes and controller/datapath command and status types for
// the LIS membership classifier.
// ----------------------------------------------------------------------------
package lis_pkg;

  localparam int MAX_ELEMENTS = 1024;
  localparam int MAX_VALUE    = 1024;

  localparam int LEAVES     = MAX_VALUE + 1;
  localparam int TREE_DEPTH = 2 * LEAVES;

  localparam int EW   = $clog2(MAX_ELEMENTS);      // element address
  localparam int CW   = $clog2(MAX_ELEMENTS + 1);  // element count
  localparam int LENW = CW;                        // subsequence length
  localparam int VW   = $clog2(MAX_VALUE + 1);     // stored value
  localparam int TW   = $clog2(TREE_DEPTH);        // tree node address

  // input field widths
  localparam int VALUE_W = 11;
  localparam int INDEX_W = 10;
  localparam int LISL_W  = 11;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] CAT_NONE = 2'd0;
  localparam logic [1:0] CAT_SOME = 2'd1;
  localparam logic [1:0] CAT_ALL  = 2'd2;

  typedef enum logic [4:0] {
    OP_NONE      = 5'd0,
    OP_LOAD      = 5'd1,
    OP_READ      = 5'd2,
    OP_OUT       = 5'd3,
    OP_CLR       = 5'd4,
    OP_INIT      = 5'd5,
    OP_ELEM_RD   = 5'd6,
    OP_ELEM_WT   = 5'd7,
    OP_RD_L      = 5'd8,
    OP_RD_R      = 5'd9,
    OP_SHIFT     = 5'd10,
    OP_ACC_RD_R  = 5'd11,
    OP_ACC_SHIFT = 5'd12,
    OP_WR        = 5'd13,
    OP_U_LEAF    = 5'd14,
    OP_U_RDL     = 5'd15,
    OP_U_RDR     = 5'd16,
    OP_U_WR      = 5'd17,
    OP_NEXT      = 5'd18,
    OP_T_RD      = 5'd19,
    OP_T_WT      = 5'd20,
    OP_FINISH    = 5'd21
  } op_t;

  typedef enum logic [2:0] {
    SW_END       = 3'd0,
    SW_START     = 3'd1,
    SW_THROUGH   = 3'd2,
    SW_RIVAL_FWD = 3'd3,
    SW_RIVAL_BWD = 3'd4
  } sweep_t;

  typedef struct packed {
    op_t    op;
    sweep_t sweep;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic l_lt_r;
    logic l_odd;
    logic r_odd;
    logic p_root;
    logic last_elem;
    logic out_busy;
  } sts_t;

  function automatic logic [LENW-1:0] len_max(input logic [LENW-1:0] a,
                                              input logic [LENW-1:0] b);
    return (a > b) ? a : b;
  endfunction

endpackage

// File: rtl/lis_ram.sv
// ----------------------------------------------------------------------------
// lis_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module lis_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// File: rtl/lis_ctrl.sv
// ----------------------------------------------------------------------------
// lis_ctrl
// Sequencer: input handshake, tree clear passes, query and update walks
// and the order of the sweeps.
// ----------------------------------------------------------------------------
module lis_ctrl import lis_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_kind,
  input  logic in_last,
  input  sts_t sts,
  output cmd_t cmd,
  output logic in_ready
);

  typedef enum logic [16:0] {
    ST_IDLE    = 17'b00000000000000001,
    ST_RD      = 17'b00000000000000010,
    ST_CLR     = 17'b00000000000000100,
    ST_INIT    = 17'b00000000000001000,
    ST_ELEM_RD = 17'b00000000000010000,
    ST_ELEM_WT = 17'b00000000000100000,
    ST_Q_TOP   = 17'b00000000001000000,
    ST_Q_LW    = 17'b00000000010000000,
    ST_Q_RW    = 17'b00000000100000000,
    ST_WR      = 17'b00000001000000000,
    ST_U_LEAF  = 17'b00000010000000000,
    ST_U_RDL   = 17'b00000100000000000,
    ST_U_RDR   = 17'b00001000000000000,
    ST_U_WR    = 17'b00010000000000000,
    ST_NEXT    = 17'b00100000000000000,
    ST_T_RD    = 17'b01000000000000000,
    ST_T_WT    = 17'b10000000000000000
  } state_t;

  state_t state, state_next;
  sweep_t sweep, sweep_next;
  op_t    op;

  assign in_ready  = (state == ST_IDLE);
  assign cmd.op    = op;
  assign cmd.sweep = sweep;

  always_comb begin
    state_next = state;
    sweep_next = sweep;
    op         = OP_NONE;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_kind == KIND_READ) begin
            op         = OP_READ;
            state_next = ST_RD;
          end else begin
            op = OP_LOAD;
            if (in_last) begin
              sweep_next = SW_END;
              state_next = ST_CLR;
            end
          end
        end
      end
      ST_RD: begin
        if (!sts.out_busy) begin
          op         = OP_OUT;
          state_next = ST_IDLE;
        end
      end
      ST_CLR: begin
        op = OP_CLR;
        if (sts.clr_done) state_next = ST_INIT;
      end
      ST_INIT: begin
        op         = OP_INIT;
        state_next = (sweep == SW_THROUGH) ? ST_T_RD : ST_ELEM_RD;
      end
      ST_ELEM_RD: begin
        op         = OP_ELEM_RD;
        state_next = ST_ELEM_WT;
      end
      ST_ELEM_WT: begin
        op         = OP_ELEM_WT;
        state_next = ST_Q_TOP;
      end
      ST_Q_TOP: begin
        if (!sts.l_lt_r) begin
          state_next = ST_WR;
        end else if (sts.l_odd) begin
          op         = OP_RD_L;
          state_next = ST_Q_LW;
        end else if (sts.r_odd) begin
          op         = OP_RD_R;
          state_next = ST_Q_RW;
        end else begin
          op = OP_SHIFT;
        end
      end
      ST_Q_LW: begin
        if (sts.r_odd) begin
          op         = OP_ACC_RD_R;
          state_next = ST_Q_RW;
        end else begin
          op         = OP_ACC_SHIFT;
          state_next = ST_Q_TOP;
        end
      end
      ST_Q_RW: begin
        op         = OP_ACC_SHIFT;
        state_next = ST_Q_TOP;
      end
      ST_WR: begin
        op         = OP_WR;
        state_next = ST_U_LEAF;
      end
      ST_U_LEAF: begin
        op         = OP_U_LEAF;
        state_next = ST_U_RDL;
      end
      ST_U_RDL: begin
        op         = OP_U_RDL;
        state_next = ST_U_RDR;
      end
      ST_U_RDR: begin
        op         = OP_U_RDR;
        state_next = ST_U_WR;
      end
      ST_U_WR: begin
        op         = OP_U_WR;
        state_next = sts.p_root ? ST_NEXT : ST_U_RDL;
      end
      ST_NEXT: begin
        if (!sts.last_elem) begin
          op         = OP_NEXT;
          state_next = ST_ELEM_RD;
        end else begin
          case (sweep)
            SW_END: begin
              sweep_next = SW_START;
              state_next = ST_CLR;
            end
            SW_START: begin
              sweep_next = SW_THROUGH;
              state_next = ST_INIT;
            end
            SW_RIVAL_FWD: begin
              sweep_next = SW_RIVAL_BWD;
              state_next = ST_CLR;
            end
            default: begin
              op         = OP_FINISH;
              state_next = ST_IDLE;
            end
          endcase
        end
      end
      ST_T_RD: begin
        op         = OP_T_RD;
        state_next = ST_T_WT;
      end
      ST_T_WT: begin
        op = OP_T_WT;
        if (sts.last_elem) begin
          sweep_next = SW_RIVAL_FWD;
          state_next = ST_CLR;
        end else begin
          state_next = ST_T_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      sweep <= SW_END;
    end else begin
      state <= state_next;
      sweep <= sweep_next;
    end
  end

endmodule

// File: rtl/lis_datapath.sv
// ----------------------------------------------------------------------------
// lis_datapath
// Element stores, max segment tree, query/update registers and the result
// register, driven by commands from the sequencer.
// ----------------------------------------------------------------------------
module lis_datapath import lis_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output sts_t               sts,
  input  logic [VALUE_W-1:0] value,
  input  logic [INDEX_W-1:0] index,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [1:0]         m_cat,
  output logic [LISL_W-1:0]  m_len,
  output logic               m_ovf
);

  logic [CW-1:0]   count;
  logic            ovf;
  logic            finished;
  logic [LENW-1:0] longest;
  logic [EW-1:0]   i;
  logic [VW-1:0]   vreg;
  logic [LENW-1:0] treg;
  logic [1:0]      creg;
  logic [TW-1:0]   l, r, p;
  logic [LENW-1:0] best, x, tmp;
  logic [TW-1:0]   clr_cnt;
  logic            rd_hit;

  // store ports
  logic            ev_we, ev_re;
  logic [EW-1:0]   ev_addr;
  logic [VW-1:0]   ev_wdata, ev_rdata;
  logic            en_we, en_re, st_we, st_re, th_we, th_re, cl_we, cl_re;
  logic [EW-1:0]   cl_addr;
  logic [LENW-1:0] en_rdata, st_rdata, th_wdata, th_rdata;
  logic [1:0]      cl_wdata, cl_rdata;
  logic            tr_we, tr_re;
  logic [TW-1:0]   tr_addr;
  logic [LENW-1:0] tr_wdata, tr_rdata;

  logic [CW-1:0]   cnt_eff;
  logic            backward;
  logic [TW:0]     v_ext, lo, hi;
  logic            empty;
  logic [LENW-1:0] best_inc;
  logic [1:0]      cat_wr;
  logic [LENW:0]   t_sum;

  assign cnt_eff  = finished ? '0 : count;
  assign backward = (cmd.sweep == SW_START) || (cmd.sweep == SW_RIVAL_BWD);
  assign best_inc = best + LENW'(1);
  assign t_sum    = (LENW+1)'(st_rdata) + (LENW+1)'(en_rdata) - (LENW+1)'(1);

  assign sts.clr_done  = (clr_cnt == TW'(TREE_DEPTH - 1));
  assign sts.l_lt_r    = (l < r);
  assign sts.l_odd     = l[0];
  assign sts.r_odd     = r[0];
  assign sts.p_root    = (p == TW'(1));
  assign sts.last_elem = backward ? (i == '0) : (CW'(i) == count - CW'(1));
  assign sts.out_busy  = m_tvalid && !m_tready;

  // query range for the element just read
  always_comb begin
    v_ext = (TW+1)'(ev_rdata);
    lo    = '0;
    hi    = v_ext;
    empty = 1'b0;
    case (cmd.sweep)
      SW_END: begin
        hi    = v_ext - (TW+1)'(1);
        empty = (v_ext == '0);
      end
      SW_START: begin
        lo    = v_ext + (TW+1)'(1);
        hi    = (TW+1)'(MAX_VALUE);
        empty = (v_ext >= (TW+1)'(MAX_VALUE));
      end
      SW_RIVAL_FWD: begin
        lo = v_ext;
        hi = (TW+1)'(MAX_VALUE);
      end
      default: begin
        lo = '0;
        hi = v_ext;
      end
    endcase
  end

  // a full-length rival demotes an element from every LIS to some LIS
  always_comb begin
    if (cmd.sweep == SW_RIVAL_FWD) begin
      cat_wr = (treg < longest) ? CAT_NONE : CAT_ALL;
    end else begin
      cat_wr = creg;
    end
    if (best == longest && cat_wr == CAT_ALL) cat_wr = CAT_SOME;
  end

  always_comb begin
    ev_we = 1'b0; ev_re = 1'b0; ev_addr = i; ev_wdata = vreg;
    en_we = 1'b0; en_re = 1'b0;
    st_we = 1'b0; st_re = 1'b0;
    th_we = 1'b0; th_re = 1'b0; th_wdata = LENW'(t_sum);
    cl_we = 1'b0; cl_re = 1'b0; cl_addr = i; cl_wdata = cat_wr;
    tr_we = 1'b0; tr_re = 1'b0; tr_addr = p; tr_wdata = '0;
    case (cmd.op)
      OP_LOAD: begin
        ev_we    = (cnt_eff < CW'(MAX_ELEMENTS));
        ev_addr  = cnt_eff[EW-1:0];
        ev_wdata = (32'(value) > 32'(MAX_VALUE)) ? VW'(MAX_VALUE) : VW'(value);
      end
      OP_READ: begin
        cl_re   = 1'b1;
        cl_addr = EW'(index);
      end
      OP_CLR: begin
        tr_we   = 1'b1;
        tr_addr = clr_cnt;
      end
      OP_ELEM_RD: begin
        ev_re = 1'b1;
        th_re = 1'b1;
        cl_re = 1'b1;
      end
      OP_RD_L: begin
        tr_re   = 1'b1;
        tr_addr = l;
      end
      OP_RD_R, OP_ACC_RD_R: begin
        tr_re   = 1'b1;
        tr_addr = r - TW'(1);
      end
      OP_WR: begin
        en_we   = (cmd.sweep == SW_END);
        st_we   = (cmd.sweep == SW_START);
        cl_we   = (cmd.sweep == SW_RIVAL_FWD) || (cmd.sweep == SW_RIVAL_BWD);
        tr_re   = 1'b1;
        tr_addr = TW'(vreg) + TW'(LEAVES);
      end
      OP_U_LEAF: begin
        tr_we    = 1'b1;
        tr_wdata = len_max(tr_rdata, x);
      end
      OP_U_RDL: begin
        tr_re   = 1'b1;
        tr_addr = {p[TW-2:0], 1'b0};
      end
      OP_U_RDR: begin
        tr_re   = 1'b1;
        tr_addr = {p[TW-2:0], 1'b1};
      end
      OP_U_WR: begin
        tr_we    = 1'b1;
        tr_wdata = len_max(tmp, tr_rdata);
      end
      OP_T_RD: begin
        en_re = 1'b1;
        st_re = 1'b1;
      end
      OP_T_WT: begin
        th_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      ovf      <= 1'b0;
      finished <= 1'b0;
      longest  <= '0;
      clr_cnt  <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.op == OP_OUT) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (cmd.op)
        OP_LOAD: begin
          if (finished) begin
            longest  <= '0;
            finished <= 1'b0;
          end
          if (cnt_eff < CW'(MAX_ELEMENTS)) begin
            count <= cnt_eff + CW'(1);
            ovf   <= finished ? 1'b0 : ovf;
          end else begin
            count <= cnt_eff;
            ovf   <= 1'b1;
          end
        end
        OP_CLR: begin
          clr_cnt <= clr_cnt + TW'(1);
        end
        OP_INIT: begin
          clr_cnt <= '0;
          if (cmd.sweep == SW_THROUGH) longest <= '0;
        end
        OP_T_WT: begin
          longest <= len_max(longest, LENW'(t_sum));
        end
        OP_FINISH: begin
          finished <= 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_READ: begin
        rd_hit <= finished && (CW'(index) < count);
      end
      OP_OUT: begin
        m_cat <= rd_hit ? cl_rdata : CAT_NONE;
        m_len <= LISL_W'(longest);
        m_ovf <= ovf;
      end
      OP_INIT: begin
        i <= backward ? EW'(count - CW'(1)) : '0;
      end
      OP_ELEM_WT: begin
        vreg <= ev_rdata;
        treg <= th_rdata;
        creg <= cl_rdata;
        best <= '0;
        if (empty || lo > hi) begin
          l <= TW'(LEAVES);
          r <= TW'(LEAVES);
        end else begin
          l <= TW'(lo + (TW+1)'(LEAVES));
          r <= TW'(hi + (TW+1)'(LEAVES + 1));
        end
      end
      OP_RD_L: begin
        l <= l + TW'(1);
      end
      OP_RD_R: begin
        r <= r - TW'(1);
      end
      OP_SHIFT: begin
        l <= l >> 1;
        r <= r >> 1;
      end
      OP_ACC_RD_R: begin
        best <= len_max(best, tr_rdata);
        r    <= r - TW'(1);
      end
      OP_ACC_SHIFT: begin
        best <= len_max(best, tr_rdata);
        l    <= l >> 1;
        r    <= r >> 1;
      end
      OP_WR: begin
        p <= TW'(vreg) + TW'(LEAVES);
        x <= (cmd.sweep == SW_END || cmd.sweep == SW_START) ? best_inc : treg;
      end
      OP_U_LEAF: begin
        p <= p >> 1;
      end
      OP_U_RDR: begin
        tmp <= tr_rdata;
      end
      OP_U_WR: begin
        p <= p >> 1;
      end
      OP_NEXT: begin
        i <= backward ? i - EW'(1) : i + EW'(1);
      end
      OP_T_WT: begin
        i <= i + EW'(1);
      end
      default: begin
      end
    endcase
  end

  lis_ram #(.WIDTH(VW), .DEPTH(MAX_ELEMENTS)) u_values (
    .clk(clk), .we(ev_we), .re(ev_re), .addr(ev_addr), .wdata(ev_wdata), .rdata(ev_rdata)
  );

  lis_ram #(.WIDTH(LENW), .DEPTH(MAX_ELEMENTS)) u_ending (
    .clk(clk), .we(en_we), .re(en_re), .addr(i), .wdata(best_inc), .rdata(en_rdata)
  );

  lis_ram #(.WIDTH(LENW), .DEPTH(MAX_ELEMENTS)) u_starting (
    .clk(clk), .we(st_we), .re(st_re), .addr(i), .wdata(best_inc), .rdata(st_rdata)
  );

  lis_ram #(.WIDTH(LENW), .DEPTH(MAX_ELEMENTS)) u_through (
    .clk(clk), .we(th_we), .re(th_re), .addr(i), .wdata(th_wdata), .rdata(th_rdata)
  );

  lis_ram #(.WIDTH(2), .DEPTH(MAX_ELEMENTS)) u_class (
    .clk(clk), .we(cl_we), .re(cl_re), .addr(cl_addr), .wdata(cl_wdata), .rdata(cl_rdata)
  );

  lis_ram #(.WIDTH(LENW), .DEPTH(TREE_DEPTH)) u_tree (
    .clk(clk), .we(tr_we), .re(tr_re), .addr(tr_addr), .wdata(tr_wdata), .rdata(tr_rdata)
  );

endmodule

// File: rtl/lis_membership_classifier.sv
// ----------------------------------------------------------------------------
// lis_membership_classifier
// Classifies each element of a loaded sequence as in no, some or every
// longest strictly increasing subsequence.
// ----------------------------------------------------------------------------
// The slave stream carries load beats (tuser = 0) and read beats (tuser = 1).
// A load beat stores one value; tlast on a load ends the sequence and starts
// the computation. The next load after that begins a new sequence. Loads past
// capacity are dropped and raise the overflow flag. A read beat asks for the
// class of element tdata.index and gives one master beat with the LIS length
// and overflow flag. Computation: four tree sweeps, each preceded by a clear
// pass over all 2050 words of the tree memory, plus one pass over the
// elements. Each element costs per sweep a root-ward query walk and an update
// walk through the single-port tree memory, about 11 levels each.
// tready is low during the computation and while a read waits on a stalled
// master; a waiting result holds until taken, and loads are still taken.
// Reset is synchronous; afterwards no sequence exists and reads return class
// 0 and length 0.
// ----------------------------------------------------------------------------
module lis_membership_classifier import lis_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // value[10:0], index[20:11], zero pad
  input  logic        s_tuser,   // kind
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // category[1:0], lis_length[12:2], overflow[13]
);

  cmd_t              cmd;
  sts_t              sts;
  logic [1:0]        cat;
  logic [LISL_W-1:0] len;
  logic              ovf;

  lis_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_kind  (s_tuser),
    .in_last  (s_tlast),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (s_tready)
  );

  lis_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .value    (s_tdata[10:0]),
    .index    (s_tdata[20:11]),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_cat    (cat),
    .m_len    (len),
    .m_ovf    (ovf)
  );

  assign m_tdata = {2'b00, ovf, len, cat};

endmodule

// File: verif/lis_membership_classifier_test.sv
// ----------------------------------------------------------------------------
// lis_membership_classifier_test
// Streams load and read beats into the classifier, keeps its own LIS
// classification of each loaded sequence and checks every read result.
// ----------------------------------------------------------------------------
module lis_membership_classifier_test import lis_pkg::*; ();

  localparam int MAX_VAL = 1024;
  localparam int MAX_EL  = 1024;
  localparam int WATCHDOG_LIMIT = 2000000;

  typedef struct packed {
    logic        kind;
    logic [10:0] value;
    logic        last;
    logic [9:0]  index;
  } req_t;

  // same bit order as the master tdata: category in the lowest bits
  typedef struct packed {
    logic        overflow;
    logic [10:0] lis_length;
    logic [1:0]  category;
  } ans_t;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;
  logic        s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;

  lis_membership_classifier dut (.*);

  req_t pending_beats[$];
  ans_t expected_answers[$];
  int   mismatch_count;
  int   idle_cycles;
  bit   timed_out;

  // classifier shadow state
  int   seq_vals[MAX_EL];
  logic [1:0] seq_class[MAX_EL];
  int   seq_count;
  int   seq_lis;
  bit   seq_overflow;
  bit   seq_done;
  int   seg[2*(MAX_VAL+1)];
  int   end_len[MAX_EL];
  int   start_len[MAX_EL];
  int   thru_len[MAX_EL];

  function automatic void seg_clear();
    foreach (seg[k]) seg[k] = 0;
  endfunction

  function automatic void seg_raise(int v, int x);
    int p;
    p = v + MAX_VAL + 1;
    if (x > seg[p]) seg[p] = x;
    for (p = p >> 1; p >= 1; p = p >> 1)
      seg[p] = (seg[2*p] > seg[2*p+1]) ? seg[2*p] : seg[2*p+1];
  endfunction

  function automatic int seg_max(int lo, int hi);
    int best, l, r;
    best = 0;
    if (lo < 0) lo = 0;
    if (hi > MAX_VAL) hi = MAX_VAL;
    if (lo > hi) return 0;
    l = lo + MAX_VAL + 1;
    r = hi + MAX_VAL + 2;
    while (l < r) begin
      if (l & 1) begin
        if (seg[l] > best) best = seg[l];
        l++;
      end
      if (r & 1) begin
        r--;
        if (seg[r] > best) best = seg[r];
      end
      l = l >> 1;
      r = r >> 1;
    end
    return best;
  endfunction

  function automatic void classify_sequence();
    int v;
    seg_clear();
    for (int i = 0; i < seq_count; i++) begin
      v = seq_vals[i];
      end_len[i] = seg_max(0, v - 1) + 1;
      seg_raise(v, end_len[i]);
    end
    seg_clear();
    for (int i = seq_count - 1; i >= 0; i--) begin
      v = seq_vals[i];
      start_len[i] = seg_max(v + 1, MAX_VAL) + 1;
      seg_raise(v, start_len[i]);
    end
    seq_lis = 0;
    for (int i = 0; i < seq_count; i++) begin
      thru_len[i] = start_len[i] + end_len[i] - 1;
      if (thru_len[i] > seq_lis) seq_lis = thru_len[i];
    end
    for (int i = 0; i < seq_count; i++)
      seq_class[i] = (thru_len[i] < seq_lis) ? CAT_NONE : CAT_ALL;
    // a full-length rival at or above earlier, or at or below later
    seg_clear();
    for (int i = 0; i < seq_count; i++) begin
      v = seq_vals[i];
      if (seg_max(v, MAX_VAL) == seq_lis && seq_class[i] == CAT_ALL) seq_class[i] = CAT_SOME;
      seg_raise(v, thru_len[i]);
    end
    seg_clear();
    for (int i = seq_count - 1; i >= 0; i--) begin
      v = seq_vals[i];
      if (seg_max(0, v) == seq_lis && seq_class[i] == CAT_ALL) seq_class[i] = CAT_SOME;
      seg_raise(v, thru_len[i]);
    end
  endfunction

  function automatic void predict_beat(req_t b);
    int v;
    ans_t a;
    if (b.kind == KIND_LOAD) begin
      if (seq_done) begin
        seq_count = 0;
        seq_lis = 0;
        seq_overflow = 0;
        seq_done = 0;
      end
      v = (b.value > MAX_VAL) ? MAX_VAL : int'(b.value);
      if (seq_count < MAX_EL) seq_vals[seq_count++] = v;
      else seq_overflow = 1;
      if (b.last) begin
        classify_sequence();
        seq_done = 1;
      end
    end else begin
      a.category = (seq_done && b.index < seq_count) ? seq_class[b.index] : CAT_NONE;
      a.lis_length = seq_lis[10:0];
      a.overflow = seq_overflow;
      expected_answers.push_back(a);
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch: %s got %0d expected %0d", what, got, want);
    mismatch_count++;
  endtask

  function automatic req_t load_beat(int v, bit l);
    req_t b;
    b = '0;
    b.kind = KIND_LOAD;
    b.value = v[10:0];
    b.last = l;
    b.index = 10'($urandom());
    return b;
  endfunction

  function automatic req_t read_beat(int idx);
    req_t b;
    b = '0;
    b.kind = KIND_READ;
    b.value = 11'($urandom());
    b.last = 1'($urandom_range(0, 1));
    b.index = idx[9:0];
    return b;
  endfunction

  task automatic queue_reads(int n, int cnt);
    for (int k = 0; k < n; k++)
      pending_beats.push_back(read_beat(
        ($urandom_range(0, 7) == 0 || cnt == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, cnt - 1)));
  endtask

  task automatic drive_beat(req_t b);
    s_tvalid <= 1'b1;
    s_tdata <= {3'b0, b.index, b.value};
    s_tuser <= b.kind;
    s_tlast <= b.last;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver
  int send_gap;
  int send_draw;
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 0;
      s_tdata <= '0;
      s_tuser <= 0;
      s_tlast <= 0;
      send_gap <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_beat(pending_beats.pop_front());
        send_draw = $urandom_range(0, 4);
        if (send_draw == 0 && pending_beats.size() > 0) begin
          drive_beat(pending_beats[0]);
        end else begin
          s_tvalid <= 0;
          send_gap <= (send_draw == 0) ? 0 : send_draw - 1;
        end
      end else if (!s_tvalid) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
        end else if (pending_beats.size() > 0) begin
          drive_beat(pending_beats[0]);
        end
      end
    end
  end

  // monitor with random stalls
  int recv_gap;
  int recv_draw;
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 0;
      recv_gap <= 0;
      idle_cycles <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        ans_t got, want;
        got = m_tdata[13:0];
        if (expected_answers.size() == 0) begin
          report_mismatch("unexpected result beat", m_tdata, 0);
        end else begin
          want = expected_answers.pop_front();
          if (got.category != want.category)
            report_mismatch("category", got.category, want.category);
          if (got.lis_length != want.lis_length)
            report_mismatch("lis_length", got.lis_length, want.lis_length);
          if (got.overflow != want.overflow)
            report_mismatch("overflow", got.overflow, want.overflow);
        end
        recv_draw = $urandom_range(0, 4);
        recv_gap <= (recv_draw == 0) ? 0 : recv_draw - 1;
        m_tready <= (recv_draw == 0);
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("** lis_membership_classifier: FAILED **");
      $finish;
    end
  end

  initial begin
    int n, mode, total;
    mismatch_count = 0;
    timed_out = 0;
    seq_count = 0;
    seq_lis = 0;
    seq_overflow = 0;
    seq_done = 0;
    rst = 1;

    // directed: read before any sequence, extremes, zero, saturation, ties
    pending_beats.push_back(read_beat(0));
    pending_beats.push_back(load_beat(0, 0));
    pending_beats.push_back(load_beat(1024, 0));
    pending_beats.push_back(load_beat(2047, 0));
    pending_beats.push_back(read_beat(1));
    pending_beats.push_back(load_beat(5, 0));
    pending_beats.push_back(load_beat(5, 0));
    pending_beats.push_back(load_beat(1025, 1));
    for (int i = 0; i < 7; i++) pending_beats.push_back(read_beat(i));
    pending_beats.push_back(read_beat(1023));
    pending_beats.push_back(load_beat(1, 1));
    pending_beats.push_back(read_beat(0));
    pending_beats.push_back(read_beat(1));
    // strictly increasing run: every element in every LIS
    for (int i = 0; i < 4; i++) pending_beats.push_back(load_beat(i * 300 + 1, i == 3));
    pending_beats.push_back(read_beat(2));
    // full capacity and overflow: one sequence of 1026 loads
    for (int i = 0; i < 1026; i++)
      pending_beats.push_back(load_beat(i < 1024 ? $urandom_range(0, 2047) : i, i == 1025));
    pending_beats.push_back(read_beat(1023));
    queue_reads(4, 1024);

    // random sequences, mostly short
    total = 0;
    while (total < 100) begin
      mode = $urandom_range(0, 9);
      n = (mode == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
      for (int i = 0; i < n; i++) begin
        int v;
        v = (mode < 5) ? $urandom_range(1, 16) : $urandom_range(0, 2047);
        pending_beats.push_back(load_beat(v, i == n - 1));
        if ($urandom_range(0, 15) == 0) queue_reads(1, 0);
      end
      queue_reads($urandom_range(2, 8), n);
      total += n + 5;
    end

    repeat (9) @(posedge clk);
    rst <= 0;

    while (pending_beats.size() > 0 || expected_answers.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0 && expected_answers.size() == 0)
      $display("** lis_membership_classifier: PASSED **");
    else
      $display("** lis_membership_classifier: FAILED **");
    $finish;
  end

endmodule

// File: sim.f
rtl/lis_pkg.sv
rtl/lis_ram.sv
rtl/lis_ctrl.sv
rtl/lis_datapath.sv
rtl/lis_membership_classifier.sv
verif/lis_membership_classifier_test.sv
